// ===== sv/frame_tick_pacer_with_perf_meter_defines.svh =====
// assertion macros for the pacer rtl
`ifndef FRAME_TICK_PACER_WITH_PERF_METER_DEFINES_SVH
`define FRAME_TICK_PACER_WITH_PERF_METER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FTP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ftp assertion failed");

// next-cycle implication, checked outside reset
`define FTP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ftp assertion failed");

`endif

// ===== sv/ftp_pkg.sv =====
`timescale 1ns / 1ps
package ftp_pkg;

   localparam int WINDOW_FRAMES = 120;
   localparam int RING_AW       = $clog2(WINDOW_FRAMES);
   localparam int FILL_W        = $clog2(WINDOW_FRAMES + 1);
   localparam int TOTAL_W       = 16 + FILL_W;

   localparam int DIVD_W = 44;
   localparam int DIVS_W = 21;
   localparam int ITER_W = 6;

   localparam logic [ITER_W-1:0] TICK_ITER = ITER_W'(21);
   localparam logic [ITER_W-1:0] FPS_ITER  = ITER_W'(44);
   localparam logic [ITER_W-1:0] AVG_ITER  = ITER_W'(TOTAL_W);

   localparam logic [23:0] FPS_SCALE = 24'd16000000;

   localparam logic [19:0] TICK_INTERVAL_RST = 20'd50000;
   localparam logic [17:0] MAX_DELTA_RST     = 18'd250000;
   localparam logic [19:0] FPS_WINDOW_RST    = 20'd500000;
   localparam logic [15:0] BUDGET_RST        = 16'd500;
   localparam logic [9:0]  SUSTAIN_RST       = 10'd30;
   localparam logic [29:0] COOLDOWN_RST      = 30'd10000000;

   typedef enum logic [2:0] {
      CSR_TICK_INTERVAL = 3'd0,
      CSR_MAX_DELTA     = 3'd1,
      CSR_FPS_WINDOW    = 3'd2,
      CSR_BUDGET        = 3'd3,
      CSR_SUSTAIN       = 3'd4,
      CSR_COOLDOWN      = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_TICK_GO,
      ST_TICK_W,
      ST_FPS_MUL,
      ST_FPS_GO,
      ST_FPS_W,
      ST_RING_RD,
      ST_RING_WR,
      ST_WARN,
      ST_AVG_GO,
      ST_AVG_W,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [47:0] timestamp_us;
      logic        work_needed;
      logic [15:0] pipeline_us;
   } req_type;

   typedef struct packed {
      logic        frame_done;
      logic [39:0] frame_number;
      logic [7:0]  ticks_fired;
      logic [39:0] tick_number;
      logic [23:0] fps_q4;
      logic [15:0] average_us;
      logic [15:0] worst_us;
      logic        warned;
      logic [31:0] warning_total;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
      logic [ITER_W-1:0] iterations;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
      logic [DIVS_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [RING_AW-1:0] addr;
      logic [15:0]        wr_data;
   } ring_req_type;

endpackage

// ===== sv/ftp_div.sv =====
`timescale 1ns / 1ps
module ftp_div
   import ftp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [ITER_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W:0]   shifted;
   logic [DIVS_W:0]   trial;

   // one restoring step a cycle, dividend shifts out as the quotient shifts in
   always_comb begin
      shifted  = {rem_ff, quo_ff[DIVD_W-1]};
      trial    = shifted - {1'b0, dvs_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = '0;
         quo_in   = req.dividend;
         dvs_in   = req.divisor;
         count_in = req.iterations;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         count_in = count_ff - ITER_W'(1);
         if (count_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== sv/ftp_ring.sv =====
`timescale 1ns / 1ps
module ftp_ring
   import ftp_pkg::*;
(
   input  logic         clock,
   input  ring_req_type req,
   output logic [15:0]  rd_data
);

   logic [15:0] mem [WINDOW_FRAMES];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/frame_tick_pacer_with_perf_meter.sv =====
`timescale 1ns / 1ps
// per item: delta, tick division, then the fps multiply and division only when the fps
// figure is recomputed, ring read and write, warning check, average division and output;
// a suppressed frame goes from delta to output. The shared one-bit-a-cycle divider runs
// 21, 44 and 23 steps. One item at a time: the next is accepted the cycle after the
// result is registered, and the output state waits while the result side stalls
`include "frame_tick_pacer_with_perf_meter_defines.svh"
module frame_tick_pacer_with_perf_meter
   import ftp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [29:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [19:0] tick_interval_ff;
   logic [17:0] max_delta_ff;
   logic [19:0] fps_window_ff;
   logic [15:0] budget_ff;
   logic [9:0]  sustain_ff;
   logic [29:0] cooldown_ff;

   req_type            item_ff;
   logic [17:0]        delta_ff;
   logic [47:0]        last_time_ff;
   logic               have_time_ff;
   logic [20:0]        tick_accum_ff;
   logic [39:0]        frame_count_ff;
   logic [39:0]        tick_count_ff;
   logic [20:0]        fps_time_ff;
   logic [19:0]        fps_frame_ff;
   logic [23:0]        fps_value_ff;
   logic [43:0]        prod_ff;
   logic [FILL_W-1:0]  sample_fill_ff;
   logic [RING_AW-1:0] cursor_ff;
   logic [TOTAL_W-1:0] sample_total_ff;
   logic [15:0]        worst_ff;
   logic [9:0]         streak_ff;
   logic [47:0]        last_warn_ff;
   logic [31:0]        warn_count_ff;
   logic [15:0]        average_ff;
   logic               done_ff;
   logic [7:0]         fired_ff;
   logic               warned_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   ring_req_type ring_req;
   logic [15:0]  ring_rd_data;
   logic         rsp_load;

   logic [47:0]        time_diff;
   logic [17:0]        delta_c;
   logic [19:0]        interval_c;
   logic [19:0]        window_c;
   logic [9:0]         sustain_c;
   logic [20:0]        tick_acc_sum;
   logic [40:0]        tick_sum;
   logic [20:0]        fps_time_sum;
   logic [19:0]        fps_frame_inc;
   logic [9:0]         streak_c;
   logic [47:0]        warn_diff;
   logic               warn_c;
   logic [TOTAL_W-1:0] total_base;
   logic               div_wait_c;

   ftp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ftp_ring u_ring (
      .clock   (clock),
      .req     (ring_req),
      .rd_data (ring_rd_data)
   );

   assign interval_c = (tick_interval_ff == '0) ? 20'd1 : tick_interval_ff;
   assign window_c   = (fps_window_ff == '0) ? 20'd1 : fps_window_ff;
   assign sustain_c  = (sustain_ff == '0) ? 10'd1 : sustain_ff;

   always_comb begin
      time_diff = item_ff.timestamp_us - last_time_ff;
      delta_c   = '0;
      if (have_time_ff && (item_ff.timestamp_us > last_time_ff)) begin
         delta_c = (time_diff > {30'd0, max_delta_ff}) ? max_delta_ff : time_diff[17:0];
      end
   end

   assign tick_acc_sum  = tick_accum_ff + 21'(delta_ff);
   assign tick_sum      = {1'b0, tick_count_ff} + 41'(div_rsp.quotient[20:0]);
   assign fps_time_sum  = fps_time_ff + 21'(delta_ff);
   assign fps_frame_inc = (fps_frame_ff == '1) ? fps_frame_ff : fps_frame_ff + 20'd1;
   assign total_base    = (sample_fill_ff >= FILL_W'(WINDOW_FRAMES)) ?
                          sample_total_ff - TOTAL_W'(ring_rd_data) : sample_total_ff;

   always_comb begin
      streak_c = '0;
      if (item_ff.pipeline_us > budget_ff) begin
         streak_c = (streak_ff == '1) ? streak_ff : streak_ff + 10'd1;
      end
      warn_diff = item_ff.timestamp_us - last_warn_ff;
      warn_c    = (streak_c >= sustain_c) && (item_ff.timestamp_us >= last_warn_ff)
                  && (warn_diff >= {18'd0, cooldown_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_DELTA;
         ST_DELTA:   state_in = item_ff.work_needed ? ST_TICK_GO : ST_OUT;
         ST_TICK_GO: state_in = ST_TICK_W;
         ST_TICK_W: begin
            if (div_rsp.done) begin
               state_in = (fps_time_sum >= {1'b0, window_c}) ? ST_FPS_MUL : ST_RING_RD;
            end
         end
         ST_FPS_MUL: state_in = ST_FPS_GO;
         ST_FPS_GO:  state_in = ST_FPS_W;
         ST_FPS_W:   if (div_rsp.done) state_in = ST_RING_RD;
         ST_RING_RD: state_in = ST_RING_WR;
         ST_RING_WR: state_in = ST_WARN;
         ST_WARN:    state_in = ST_AVG_GO;
         ST_AVG_GO:  state_in = ST_AVG_W;
         ST_AVG_W:   if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:     if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_req          = '0;
      ring_req         = '0;
      ring_req.addr    = cursor_ff;
      ring_req.wr_data = item_ff.pipeline_us;
      rsp_load         = 1'b0;
      case (state_ff)
         ST_TICK_GO: begin
            div_req.start      = 1'b1;
            div_req.dividend   = {tick_acc_sum, 23'd0};
            div_req.divisor    = {1'b0, interval_c};
            div_req.iterations = TICK_ITER;
         end
         ST_FPS_GO: begin
            div_req.start      = 1'b1;
            div_req.dividend   = prod_ff;
            div_req.divisor    = fps_time_ff;
            div_req.iterations = FPS_ITER;
         end
         ST_AVG_GO: begin
            div_req.start      = 1'b1;
            div_req.dividend   = {sample_total_ff, (DIVD_W - TOTAL_W)'(0)};
            div_req.divisor    = DIVS_W'(sample_fill_ff);
            div_req.iterations = AVG_ITER;
         end
         ST_RING_RD: ring_req.rd_en = 1'b1;
         ST_RING_WR: ring_req.wr_en = 1'b1;
         ST_OUT:     rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         tick_interval_ff <= TICK_INTERVAL_RST;
         max_delta_ff     <= MAX_DELTA_RST;
         fps_window_ff    <= FPS_WINDOW_RST;
         budget_ff        <= BUDGET_RST;
         sustain_ff       <= SUSTAIN_RST;
         cooldown_ff      <= COOLDOWN_RST;
         last_time_ff     <= '0;
         have_time_ff     <= 1'b0;
         tick_accum_ff    <= '0;
         frame_count_ff   <= '0;
         tick_count_ff    <= '0;
         fps_time_ff      <= '0;
         fps_frame_ff     <= '0;
         fps_value_ff     <= '0;
         sample_fill_ff   <= '0;
         cursor_ff        <= '0;
         sample_total_ff  <= '0;
         worst_ff         <= '0;
         streak_ff        <= '0;
         last_warn_ff     <= '0;
         warn_count_ff    <= '0;
         average_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TICK_INTERVAL: tick_interval_ff <= csr_wdata[19:0];
               CSR_MAX_DELTA:     max_delta_ff     <= csr_wdata[17:0];
               CSR_FPS_WINDOW:    fps_window_ff    <= csr_wdata[19:0];
               CSR_BUDGET:        budget_ff        <= csr_wdata[15:0];
               CSR_SUSTAIN:       sustain_ff       <= csr_wdata[9:0];
               CSR_COOLDOWN:      cooldown_ff      <= csr_wdata[29:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_DELTA: begin
               last_time_ff <= item_ff.timestamp_us;
               have_time_ff <= 1'b1;
               if (!item_ff.work_needed) begin
                  tick_accum_ff <= '0;
               end
            end
            ST_TICK_GO: begin
               if (frame_count_ff != '1) frame_count_ff <= frame_count_ff + 40'd1;
            end
            ST_TICK_W: begin
               if (div_rsp.done) begin
                  tick_accum_ff <= div_rsp.remainder;
                  tick_count_ff <= tick_sum[40] ? '1 : tick_sum[39:0];
                  fps_time_ff   <= fps_time_sum;
                  fps_frame_ff  <= fps_frame_inc;
               end
            end
            ST_FPS_W: begin
               if (div_rsp.done) begin
                  fps_value_ff <= (div_rsp.quotient[43:24] != '0) ? '1
                                                                  : div_rsp.quotient[23:0];
                  fps_time_ff  <= '0;
                  fps_frame_ff <= '0;
               end
            end
            ST_RING_WR: begin
               if (sample_fill_ff < FILL_W'(WINDOW_FRAMES)) begin
                  sample_fill_ff <= sample_fill_ff + FILL_W'(1);
               end
               sample_total_ff <= total_base + TOTAL_W'(item_ff.pipeline_us);
               cursor_ff <= (cursor_ff == RING_AW'(WINDOW_FRAMES - 1)) ? '0
                                                                       : cursor_ff + RING_AW'(1);
               if (item_ff.pipeline_us > worst_ff) worst_ff <= item_ff.pipeline_us;
            end
            ST_WARN: begin
               streak_ff <= warn_c ? '0 : streak_c;
               if (warn_c) begin
                  last_warn_ff <= item_ff.timestamp_us;
                  if (warn_count_ff != '1) warn_count_ff <= warn_count_ff + 32'd1;
               end
            end
            ST_AVG_W: begin
               if (div_rsp.done) average_ff <= div_rsp.quotient[15:0];
            end
            default: ;
         endcase
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and per-item flags
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      case (state_ff)
         ST_DELTA: begin
            delta_ff  <= delta_c;
            done_ff   <= item_ff.work_needed;
            fired_ff  <= '0;
            warned_ff <= 1'b0;
         end
         ST_TICK_W: begin
            if (div_rsp.done) begin
               fired_ff <= (div_rsp.quotient[20:8] != '0) ? 8'hff : div_rsp.quotient[7:0];
            end
         end
         ST_FPS_MUL: prod_ff <= fps_frame_ff * FPS_SCALE;
         ST_WARN:    warned_ff <= warn_c;
         default: ;
      endcase
      if (rsp_load) begin
         rsp_data_ff.frame_done    <= done_ff;
         rsp_data_ff.frame_number  <= frame_count_ff;
         rsp_data_ff.ticks_fired   <= fired_ff;
         rsp_data_ff.tick_number   <= tick_count_ff;
         rsp_data_ff.fps_q4        <= fps_value_ff;
         rsp_data_ff.average_us    <= average_ff;
         rsp_data_ff.worst_us      <= worst_ff;
         rsp_data_ff.warned        <= warned_ff;
         rsp_data_ff.warning_total <= warn_count_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign div_wait_c = state_ff inside {ST_TICK_W, ST_FPS_W, ST_AVG_W};

   `FTP_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, sample_fill_ff <= FILL_W'(WINDOW_FRAMES))
   `FTP_ASSERT_NOW(a_cursor_bound, clock, reset, 1'b1, cursor_ff < RING_AW'(WINDOW_FRAMES))
   `FTP_ASSERT_NOW(a_div_done_waited, clock, reset, div_rsp.done, div_wait_c)
   `FTP_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff == ST_DELTA)

endmodule

// ===== test/frame_tick_pacer_with_perf_meter_tb.sv =====
`timescale 1ns / 1ps
module frame_tick_pacer_with_perf_meter_tb
   import ftp_pkg::*;
();

   localparam int LIMIT_CYCLES = 900000;

   class pacer_scoreboard;
      // settings
      logic [19:0] tick_interval;
      logic [17:0] max_delta;
      logic [19:0] fps_window;
      logic [15:0] budget;
      logic [9:0]  sustain;
      logic [29:0] cooldown;
      // block state
      logic [47:0] last_time;
      bit          have_time;
      longint unsigned tick_accum, frame_count, tick_count;
      longint unsigned fps_time, fps_count, fps_value;
      logic [15:0] samples [WINDOW_FRAMES];
      int unsigned fill, cursor, ring_total, worst, streak;
      logic [47:0] last_warn;
      longint unsigned warn_count;
      rsp_type     pending [$];
      int          mismatches;

      function new();
         tick_interval = TICK_INTERVAL_RST;
         max_delta = MAX_DELTA_RST;
         fps_window = FPS_WINDOW_RST;
         budget = BUDGET_RST;
         sustain = SUSTAIN_RST;
         cooldown = COOLDOWN_RST;
         last_time = '0;
         have_time = 0;
         tick_accum = 0; frame_count = 0; tick_count = 0;
         fps_time = 0; fps_count = 0; fps_value = 0;
         fill = 0; cursor = 0; ring_total = 0; worst = 0; streak = 0;
         last_warn = '0;
         warn_count = 0;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [29:0] v);
         case (idx)
            CSR_TICK_INTERVAL: tick_interval = v[19:0];
            CSR_MAX_DELTA:     max_delta = v[17:0];
            CSR_FPS_WINDOW:    fps_window = v[19:0];
            CSR_BUDGET:        budget = v[15:0];
            CSR_SUSTAIN:       sustain = v[9:0];
            CSR_COOLDOWN:      cooldown = v;
            default: ;
         endcase
      endfunction

      function void note_frame(req_type r);
         longint unsigned delta, intv, acc, q, win, sus, now, pipe, v;
         rsp_type e;
         now = r.timestamp_us;
         pipe = r.pipeline_us;
         delta = 0;
         e = '0;
         if (have_time && now > last_time) begin
            delta = now - last_time;
            if (delta > max_delta) delta = max_delta;
         end
         last_time = r.timestamp_us;
         have_time = 1;
         if (!r.work_needed) begin
            tick_accum = 0;
         end else begin
            e.frame_done = 1;
            if (frame_count < 40'hFF_FFFF_FFFF) frame_count++;
            intv = (tick_interval == 0) ? 1 : tick_interval;
            acc = tick_accum + delta;
            q = acc / intv;
            tick_accum = acc % intv;
            tick_count = (q > 64'hFF_FFFF_FFFF - tick_count) ? 64'hFF_FFFF_FFFF
                                                           : tick_count + q;
            e.ticks_fired = (q > 255) ? 8'd255 : q[7:0];
            win = (fps_window == 0) ? 1 : fps_window;
            fps_time += delta;
            if (fps_count < 20'hFFFFF) fps_count++;
            if (fps_time >= win) begin
               v = fps_count * 16000000 / fps_time;
               fps_value = (v > 24'hFFFFFF) ? 24'hFFFFFF : v;
               fps_time = 0;
               fps_count = 0;
            end
            if (fill >= WINDOW_FRAMES) ring_total -= samples[cursor];
            else fill++;
            samples[cursor] = r.pipeline_us;
            ring_total += pipe;
            cursor = (cursor + 1 >= WINDOW_FRAMES) ? 0 : cursor + 1;
            if (pipe > worst) worst = pipe;
            if (pipe > budget) streak = (streak < 1023) ? streak + 1 : 1023;
            else streak = 0;
            sus = (sustain == 0) ? 1 : sustain;
            if (streak >= sus && now >= last_warn && now - last_warn >= cooldown) begin
               last_warn = r.timestamp_us;
               streak = 0;
               if (warn_count < 32'hFFFF_FFFF) warn_count++;
               e.warned = 1;
            end
         end
         e.frame_number = 40'(frame_count);
         e.tick_number = 40'(tick_count);
         e.fps_q4 = 24'(fps_value);
         e.average_us = fill ? 16'(ring_total / fill) : 16'd0;
         e.worst_us = 16'(worst);
         e.warning_total = 32'(warn_count);
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [29:0] csr_wdata = '0;

   pacer_scoreboard board = new();
   int unsigned send_idle_pct = 25, recv_idle_pct = 73;
   logic [47:0] frame_clock = 48'd1000;
   longint unsigned cycle_count = 0;

   frame_tick_pacer_with_perf_meter i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("frame_tick_pacer_with_perf_meter_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // valid stays high from one item to the next unless the sender idles
   task automatic send_frame(req_type r);
      bit idle;
      idle = (send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct);
      if (idle) req_valid <= 0;
      while (idle) begin
         @(posedge clock);
         idle = ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_frame(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [29:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   // mostly forward-moving frames, some jumps backward and large gaps
   task automatic random_frame();
      req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) frame_clock += $urandom_range(20000);
      else if (pick < 80) frame_clock += $urandom_range(1500000);
      else if (pick < 88) frame_clock -= $urandom_range(5000);
      else if (pick < 92) frame_clock = 48'({$urandom, $urandom});
      else frame_clock += $urandom_range(300);
      r.timestamp_us = frame_clock;
      r.work_needed = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 60) r.pipeline_us = 16'(board.budget + $urandom_range(50) - 20);
      else if (pick < 85) r.pipeline_us = 16'($urandom_range(2000));
      else r.pipeline_us = 16'($urandom);
      send_frame(r);
   endtask

   task automatic directed_frame(logic [47:0] ts, logic w, logic [15:0] p);
      req_type r;
      r.timestamp_us = ts;
      r.work_needed = w;
      r.pipeline_us = p;
      send_frame(r);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes, backwards time, suppression, zero registers, tick bursts
      directed_frame(48'd0, 1, 16'd0);
      directed_frame(48'hFFFF_FFFF_FFFF, 1, 16'hFFFF);
      directed_frame(48'd5, 1, 16'd600);
      directed_frame(48'd40000, 0, 16'd700);
      directed_frame(48'd300000, 1, 16'hAAAA);
      directed_frame(48'd350000, 1, 16'h5555);
      drain();
      write_reg(CSR_TICK_INTERVAL, 30'd0);
      write_reg(CSR_FPS_WINDOW, 30'd0);
      write_reg(CSR_SUSTAIN, 30'd0);
      write_reg(CSR_BUDGET, 30'd0);
      write_reg(CSR_COOLDOWN, 30'd0);
      directed_frame(48'd600000, 1, 16'd1);
      directed_frame(48'd610000, 1, 16'd2);
      directed_frame(48'd610000, 1, 16'd0);
      directed_frame(48'd900000, 0, 16'd9);
      directed_frame(48'd900100, 1, 16'd9);
      drain();
      write_reg(CSR_TICK_INTERVAL, 30'd1000000);
      write_reg(CSR_MAX_DELTA, 30'd0);
      write_reg(CSR_FPS_WINDOW, 30'd750000);
      write_reg(CSR_BUDGET, 30'd65535);
      write_reg(CSR_SUSTAIN, 30'd1000);
      write_reg(CSR_COOLDOWN, 30'd1000000000);
      directed_frame(48'd2000000, 1, 16'hFFFF);
      directed_frame(48'd3000000, 1, 16'd0);
      drain();
      write_reg(CSR_TICK_INTERVAL, 30'd1000);
      write_reg(CSR_MAX_DELTA, 30'd250000);
      write_reg(CSR_FPS_WINDOW, 30'd1);
      write_reg(CSR_BUDGET, 30'd400);
      write_reg(CSR_SUSTAIN, 30'd2);
      write_reg(CSR_COOLDOWN, 30'd20000);
      for (int i = 0; i < 220; i++) random_frame();
      drain();
      frame_clock = 48'd0;
      send_idle_pct = 73;
      recv_idle_pct = 25;
      write_reg(CSR_TICK_INTERVAL, 30'd5000);
      write_reg(CSR_FPS_WINDOW, 30'd50000);
      write_reg(CSR_BUDGET, 30'd800);
      write_reg(CSR_SUSTAIN, 30'd1);
      write_reg(CSR_COOLDOWN, 30'd0);
      for (int i = 0; i < 210; i++) random_frame();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_TICK_INTERVAL, 30'd50000);
      write_reg(CSR_MAX_DELTA, 30'd100000);
      write_reg(CSR_FPS_WINDOW, 30'd500000);
      write_reg(CSR_BUDGET, 30'd500);
      write_reg(CSR_SUSTAIN, 30'd3);
      write_reg(CSR_COOLDOWN, 30'd100000);
      for (int i = 0; i < 210; i++) random_frame();
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("frame_tick_pacer_with_perf_meter_tb passed");
      end else begin
         $display("frame_tick_pacer_with_perf_meter_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ftp_pkg.sv
sv/ftp_div.sv
sv/ftp_ring.sv
sv/frame_tick_pacer_with_perf_meter.sv
test/frame_tick_pacer_with_perf_meter_tb.sv
